// ===== sv/euler_to_rotation_matrix_top_defines.svh =====
// assertion macros for the euler to rotation matrix block
// used by euler_to_rotation_matrix_top; no other dependencies
`ifndef EULER_TO_ROTATION_MATRIX_TOP_DEFINES_SVH
`define EULER_TO_ROTATION_MATRIX_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define E2R_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define E2R_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define E2R_ASSERT_IMP(label, clk, rst_n, a, c)
`define E2R_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== sv/e2r_pkg.sv =====
// shared types and constants for the euler to rotation matrix block
// no dependencies
`default_nettype none
package e2r_pkg;
  localparam int unsigned ANGLE_BITS = 16;  // binary angle width, msb weight is pi
  localparam int unsigned FRAC_BITS = 14;   // fraction bits of the matrix entries
  localparam int unsigned CW = 34;  // cordic datapath width, q2.30 plus guard
  localparam int unsigned LATENCY_EXTRA = 4;  // fold stage plus three merge stages

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
  } e2r_in_t;

  typedef struct packed {
    logic signed [FRAC_BITS+1:0] m00;
    logic signed [FRAC_BITS+1:0] m01;
    logic signed [FRAC_BITS+1:0] m02;
    logic signed [FRAC_BITS+1:0] m10;
    logic signed [FRAC_BITS+1:0] m11;
    logic signed [FRAC_BITS+1:0] m12;
    logic signed [FRAC_BITS+1:0] m20;
    logic signed [FRAC_BITS+1:0] m21;
    logic signed [FRAC_BITS+1:0] m22;
  } e2r_out_t;

  // atan(2^-i) in 32-bit binary angle units
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;   5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;     5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;       5'd21: v = 32'd326;
      5'd22: v = 32'd163;       5'd23: v = 32'd81;
      5'd24: v = 32'd41;        5'd25: v = 32'd20;
      5'd26: v = 32'd10;        5'd27: v = 32'd5;
      5'd28: v = 32'd3;         5'd29: v = 32'd1;
      5'd30: v = 32'd1;         default: v = 32'd0;
    endcase
    return v;
  endfunction

  // q30 product with round half up
  function automatic logic signed [CW-1:0] qmul(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    p = (2*CW)'(a) * (2*CW)'(b) + (2*CW)'(64'sd1 <<< 29);
    return CW'(p >>> 30);
  endfunction
endpackage
`default_nettype wire

// ===== sv/euler_to_rotation_matrix_top.sv =====
// channel | ports                    | meaning
// input   | start, busy, in_data     | one angle triple per transaction
// result  | out_valid, out_data      | nine matrix entries, one-cycle strobe
// a triple may be started every cycle; busy stays low, also in reset
// the data path holds one fold stage, one stage per cordic
// iteration and three product/sum stages, the last being the output register
// reset clears only the valid pipeline; data registers are not reset
// the receiver cannot stall, so nothing is held back
// depends on e2r_pkg, e2r_cordic_lane, e2r_merge and the defines header
`default_nettype none
`include "euler_to_rotation_matrix_top_defines.svh"
module euler_to_rotation_matrix_top
  import e2r_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire e2r_in_t in_data,
  output logic      out_valid,
  output e2r_out_t  out_data
);
  localparam int unsigned NS  = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int unsigned LAT = NS + LATENCY_EXTRA;

  logic signed [CW-1:0] sr, cr, sp, cp, sy, cy;
  logic [LAT-1:0] vld_r, vld_nxt;

  assign busy = 1'b0;

  // three sine/cosine lanes
  e2r_cordic_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .angle(in_data.roll_angle), .sin_q(sr), .cos_q(cr));
  e2r_cordic_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .angle(in_data.pitch_angle), .sin_q(sp), .cos_q(cp));
  e2r_cordic_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .angle(in_data.yaw_angle), .sin_q(sy), .cos_q(cy));

  e2r_merge u_merge (
    .clk(clk), .sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy), .res(out_data));

  // transaction valid pipeline
  assign vld_nxt = {vld_r[LAT-2:0], start & ~busy};
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= vld_nxt;
  end
  assign out_valid = vld_r[LAT-1];

  `E2R_ASSERT_NXT(a_valid_follows, clk, rst_n, vld_r[LAT-2], out_valid)
  `E2R_ASSERT_IMP(a_never_busy, clk, rst_n, 1'b1, !busy)
  `E2R_ASSERT_NXT(a_entry_tracked, clk, rst_n, start, vld_r[0])
endmodule
`default_nettype wire

// ===== sv/e2r_cordic_lane.sv =====
// pipelined cordic sine/cosine lane, one iteration per stage
// depends on e2r_pkg
`default_nettype none
module e2r_cordic_lane
  import e2r_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                  clk,
  input  wire logic [ANGLE_BITS-1:0] angle,
  output logic signed [CW-1:0]       sin_q,
  output logic signed [CW-1:0]       cos_q
);
  localparam int unsigned NS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  logic signed [CW-1:0] x_r [NS+1];
  logic signed [CW-1:0] y_r [NS+1];
  logic signed [32:0]   z_r [NS+1];
  logic                 flip_r [NS+1];

  // quadrant fold into the right half plane
  logic [31:0] a32, af;
  logic        flip;
  assign a32  = 32'(angle) << (32 - ANGLE_BITS);
  assign flip = a32[31] ^ a32[30];
  assign af   = flip ? a32 + 32'h8000_0000 : a32;

  always_ff @(posedge clk) begin
    x_r[0]    <= CW'(64'sd652032874);
    y_r[0]    <= '0;
    z_r[0]    <= {af[31], af};
    flip_r[0] <= flip;
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < NS; i++) begin : g_step
    logic [31:0] at;
    assign at = atan_lut(5'(i));
    always_ff @(posedge clk) begin
      flip_r[i+1] <= flip_r[i];
      if (!z_r[i][32]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - $signed({1'b0, at});
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + $signed({1'b0, at});
      end
    end
  end

  assign sin_q = flip_r[NS] ? -y_r[NS] : y_r[NS];
  assign cos_q = flip_r[NS] ? -x_r[NS] : x_r[NS];
endmodule
`default_nettype wire

// ===== sv/e2r_merge.sv =====
// merge stage: products of the lane outputs into the nine matrix entries
// depends on e2r_pkg
`default_nettype none
module e2r_merge
  import e2r_pkg::*;
(
  input  wire logic              clk,
  input  wire logic signed [CW-1:0] sr, cr, sp, cp, sy, cy,
  output e2r_out_t               res
);
  localparam int unsigned OW = FRAC_BITS + 2;

  function automatic logic [OW-1:0] to_out(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r, one;
    one = CW'(64'sd1 <<< FRAC_BITS);
    if (FRAC_BITS < 30) r = (v + CW'(64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    else r = v;
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[OW-1:0];
  endfunction

  // stage 1: first products
  logic signed [CW-1:0] cysp_r, sysp_r, cycp_r, sycr_r, sysr_r, sycp_r, cycr_r, cysr_r;
  logic signed [CW-1:0] cpsr_r, cpcr_r, nsp_r, sr1_r, cr1_r;
  always_ff @(posedge clk) begin
    cysp_r <= qmul(cy, sp);  sysp_r <= qmul(sy, sp);
    cycp_r <= qmul(cy, cp);  sycr_r <= qmul(sy, cr);
    sysr_r <= qmul(sy, sr);  sycp_r <= qmul(sy, cp);
    cycr_r <= qmul(cy, cr);  cysr_r <= qmul(cy, sr);
    cpsr_r <= qmul(cp, sr);  cpcr_r <= qmul(cp, cr);
    nsp_r  <= -sp;  sr1_r <= sr;  cr1_r <= cr;
  end

  // stage 2: triple products
  logic signed [CW-1:0] a_r, b_r, c_r, d_r;
  logic signed [CW-1:0] cycp2_r, sycr2_r, sysr2_r, sycp2_r, cycr2_r, cysr2_r;
  logic signed [CW-1:0] cpsr2_r, cpcr2_r, nsp2_r;
  always_ff @(posedge clk) begin
    a_r <= qmul(cysp_r, sr1_r);  b_r <= qmul(cysp_r, cr1_r);
    c_r <= qmul(sysp_r, sr1_r);  d_r <= qmul(sysp_r, cr1_r);
    cycp2_r <= cycp_r; sycr2_r <= sycr_r; sysr2_r <= sysr_r; sycp2_r <= sycp_r;
    cycr2_r <= cycr_r; cysr2_r <= cysr_r; cpsr2_r <= cpsr_r; cpcr2_r <= cpcr_r;
    nsp2_r <= nsp_r;
  end

  // stage 3: sums, rounding and saturation
  always_ff @(posedge clk) begin
    res.m00 <= to_out(cycp2_r);
    res.m01 <= to_out(a_r - sycr2_r);
    res.m02 <= to_out(b_r + sysr2_r);
    res.m10 <= to_out(sycp2_r);
    res.m11 <= to_out(c_r + cycr2_r);
    res.m12 <= to_out(d_r - cysr2_r);
    res.m20 <= to_out(nsp2_r);
    res.m21 <= to_out(cpsr2_r);
    res.m22 <= to_out(cpcr2_r);
  end
endmodule
`default_nettype wire
